// ----- src/cmts_pkg.sv -----
// ----------------------------------------------------------------------------
// cmts_pkg
// Shared types and codes of the clock mode and time setter: key bytes,
// modes, event codes, register indexes, configuration and state records.
// ----------------------------------------------------------------------------
package cmts_pkg;

    // Received key bytes
    localparam logic [7:0] KEY_UP     = 8'd65;
    localparam logic [7:0] KEY_DOWN   = 8'd66;
    localparam logic [7:0] KEY_RIGHT  = 8'd67;
    localparam logic [7:0] KEY_LEFT   = 8'd68;
    localparam logic [7:0] KEY_SELECT = 8'd13;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // Event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_TIME_SET  = 3'd1;
    localparam logic [2:0] EV_ALARM_SET = 3'd2;
    localparam logic [2:0] EV_MUSIC     = 3'd3;
    localparam logic [2:0] EV_SONG_ONE  = 3'd4;
    localparam logic [2:0] EV_SONG_TWO  = 3'd5;

    // Digit fields
    localparam logic [2:0] FIELD_AMPM = 3'd1;
    localparam logic [2:0] FIELD_HOUR = 3'd2;
    localparam logic [2:0] FIELD_MIN  = 3'd3;
    localparam logic [2:0] FIELD_SEC  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_REPEATS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SC_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS        = 3'd6;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_TIME_SET  = 2'd1,
        MODE_ALARM_SET = 2'd2,
        MODE_MUSIC     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] lp_min;
        logic [15:0] lp_max;
        logic [7:0]  lp_repeats;
        logic [15:0] dc_min;
        logic [15:0] dc_max;
        logic [15:0] sc_min;
        logic [15:0] tps;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [2:0]         field;
        logic signed [7:0]  hour;
        logic signed [7:0]  minute;
        logic signed [7:0]  second;
        logic [3:0]         al_hour;
        logic [5:0]         al_min;
        logic [5:0]         al_sec;
        logic [15:0]        tick_phase;
        logic [31:0]        last_key_ms;
        logic [7:0]         repeat_count;
    } clock_state_t;

endpackage

// ----- src/clock_mode_and_time_setter.sv -----
// ----------------------------------------------------------------------------
// clock_mode_and_time_setter
// Time of day, alarm time, mode and digit field driven by tick and key
// requests; every request returns the whole state and an event code.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        input      in_valid / in_ready   req_type, key_code, now_ms
//  out       output     out_valid / out_ready mode, field, time, alarm, event
//  cfg       input      cfg_we                cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready stays high; a request
//  passes through the input register, then next-state logic into the state
//  and result registers. While a finished result waits for out_ready, an
//  empty input register still takes one request; then the stall holds both.
//  Reset gives normal mode, am/pm field, zero times and default timings.
// ----------------------------------------------------------------------------
module clock_mode_and_time_setter
    import cmts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [7:0]            key_code,
    input  logic [31:0]           now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            op_mode,
    output logic [2:0]            field_select,
    output logic signed [7:0]     hours,
    output logic signed [7:0]     minutes,
    output logic signed [7:0]     seconds,
    output logic [3:0]            alarm_hours,
    output logic [5:0]            alarm_minutes,
    output logic [5:0]            alarm_seconds,
    output logic [2:0]            event_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t         cfg;
    clock_state_t state_reg;
    clock_state_t state_next;
    logic [2:0]   ev_next;

    logic         in_valid_reg;
    logic         req_type_reg;
    logic [7:0]   key_code_reg;
    logic [31:0]  now_ms_reg;

    logic         out_valid_reg;
    clock_state_t res_reg;
    logic [2:0]   ev_reg;
    logic         fire;

    cmts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmts_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .req_type   (req_type_reg),
        .key_code   (key_code_reg),
        .now_ms     (now_ms_reg),
        .nxt        (state_next),
        .event_code (ev_next)
    );

    // Process the held request when the result slot is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Capture requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            key_code_reg <= key_code;
            now_ms_reg   <= now_ms;
        end
    end

    // Advance the clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_NORMAL, field: FIELD_AMPM, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= state_next;
            ev_reg  <= ev_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign op_mode       = res_reg.mode;
    assign field_select  = res_reg.field;
    assign hours         = res_reg.hour;
    assign minutes       = res_reg.minute;
    assign seconds       = res_reg.second;
    assign alarm_hours   = res_reg.al_hour;
    assign alarm_minutes = res_reg.al_min;
    assign alarm_seconds = res_reg.al_sec;
    assign event_code    = ev_reg;

    // Field stays within am/pm .. seconds
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.field >= FIELD_AMPM) && (state_reg.field <= FIELD_SEC))
        else $error("field select left its range");

    // Alarm values stay clamped
    a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.al_hour <= 4'd12) && (state_reg.al_min <= 6'd60)
        && (state_reg.al_sec <= 6'd60))
        else $error("alarm value out of clamp range");

    // A processed request always yields a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request produced no result");

    // Alarm-entry event reports alarm setting mode
    a_alarm_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg == EV_ALARM_SET) |-> (res_reg.mode == MODE_ALARM_SET))
        else $error("alarm event without alarm setting mode");

endmodule

// ----- src/cmts_cfg.sv -----
// ----------------------------------------------------------------------------
// cmts_cfg
// Configuration register file: timing windows, repeat count and tick rate.
// ----------------------------------------------------------------------------
module cmts_cfg
    import cmts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; hold the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lp_min     <= 16'd20;
            cfg_reg.lp_max     <= 16'd50;
            cfg_reg.lp_repeats <= 8'd30;
            cfg_reg.dc_min     <= 16'd100;
            cfg_reg.dc_max     <= 16'd200;
            cfg_reg.sc_min     <= 16'd500;
            cfg_reg.tps        <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LP_MIN:     cfg_reg.lp_min     <= cfg_data;
                CFG_LP_MAX:     cfg_reg.lp_max     <= cfg_data;
                CFG_LP_REPEATS: cfg_reg.lp_repeats <= cfg_data[7:0];
                CFG_DC_MIN:     cfg_reg.dc_min     <= cfg_data;
                CFG_DC_MAX:     cfg_reg.dc_max     <= cfg_data;
                CFG_SC_MIN:     cfg_reg.sc_min     <= cfg_data;
                CFG_TPS:        cfg_reg.tps        <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/cmts_step.sv -----
// ----------------------------------------------------------------------------
// cmts_step
// Next-state logic for one request: tick handling with seconds advance, and
// key handling with select timing, field moves and value adjustment.
// ----------------------------------------------------------------------------
module cmts_step
    import cmts_pkg::*;
(
    input  clock_state_t cur,
    input  cfg_t         cfg,
    input  logic         req_type,
    input  logic [7:0]   key_code,
    input  logic [31:0]  now_ms,
    output clock_state_t nxt,
    output logic [2:0]   event_code
);

    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        logic signed [7:0] r;
        if (v > 10'sd127)
            r = 8'sh7F;
        else if (v < -10'sd128)
            r = 8'sh80;
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic logic [5:0] alarm_clamp(input logic signed [9:0] v,
                                               input logic signed [9:0] hi);
        logic [5:0] r;
        if (v > hi || v <= 10'sd0)
            r = 6'd0;
        else
            r = v[5:0];
        return r;
    endfunction

    // Key interval and timing windows
    logic [31:0] gap;
    logic        lp_hit;
    logic        dc_hit;
    logic        slow;
    logic [7:0]  rc_inc;

    assign gap    = now_ms - cur.last_key_ms;
    assign lp_hit = (gap >= {16'd0, cfg.lp_min}) && (gap <= {16'd0, cfg.lp_max});
    assign dc_hit = (gap >= {16'd0, cfg.dc_min}) && (gap <= {16'd0, cfg.dc_max});
    assign slow   = (gap >= {16'd0, cfg.sc_min});
    assign rc_inc = (cur.repeat_count == 8'hFF) ? cur.repeat_count
                                                : cur.repeat_count + 8'd1;

    // Seconds advance with normalization
    logic [15:0]       tps_eff;
    logic signed [8:0] s_inc;
    logic signed [8:0] m_base;
    logic signed [8:0] h_base;
    logic              s_wrap;
    logic              m_wrap;
    logic signed [7:0] sec_adv;
    logic signed [7:0] min_adv;
    logic signed [7:0] hour_adv;

    assign tps_eff = (cfg.tps == 16'd0) ? 16'd1 : cfg.tps;
    assign s_inc   = {cur.second[7], cur.second} + 9'sd1;
    assign s_wrap  = (s_inc >= 9'sd60);
    assign m_base  = {cur.minute[7], cur.minute} + (s_wrap ? 9'sd1 : 9'sd0);
    assign m_wrap  = (m_base >= 9'sd60);
    assign h_base  = {cur.hour[7], cur.hour} + (m_wrap ? 9'sd1 : 9'sd0);
    assign sec_adv = (s_wrap || s_inc < 9'sd0) ? 8'sd0 : s_inc[7:0];
    assign min_adv = (m_wrap || m_base < 9'sd0) ? 8'sd0 : m_base[7:0];
    assign hour_adv = (h_base >= 9'sd24 || h_base < 9'sd0) ? 8'sd0 : h_base[7:0];

    // Adjust amounts: twelve hours in the am/pm field, else one
    logic              is_up;
    logic signed [9:0] step;
    logic signed [9:0] hour_sum;
    logic signed [9:0] min_sum;
    logic signed [9:0] sec_sum;
    logic signed [9:0] al_hour_sum;
    logic signed [9:0] al_min_sum;
    logic signed [9:0] al_sec_sum;

    assign is_up = (key_code == KEY_UP);
    always_comb
    begin
        if (cur.field == FIELD_AMPM)
            step = is_up ? 10'sd12 : -10'sd12;
        else
            step = is_up ? 10'sd1 : -10'sd1;
    end
    assign hour_sum    = {{2{cur.hour[7]}}, cur.hour} + step;
    assign min_sum     = {{2{cur.minute[7]}}, cur.minute} + step;
    assign sec_sum     = {{2{cur.second[7]}}, cur.second} + step;
    assign al_hour_sum = {6'd0, cur.al_hour} + step;
    assign al_min_sum  = {4'd0, cur.al_min} + step;
    assign al_sec_sum  = {4'd0, cur.al_sec} + step;

    // Field moves, cyclic through 1..4
    logic [2:0] field_right;
    logic [2:0] field_left;

    assign field_right = (cur.field >= FIELD_SEC || cur.field == 3'd0) ? FIELD_AMPM
                                                                      : cur.field + 3'd1;
    assign field_left  = (cur.field <= FIELD_AMPM || cur.field > FIELD_SEC) ? FIELD_SEC
                                                                           : cur.field - 3'd1;

    // Apply the request
    logic [7:0] rc_mid;

    always_comb
    begin
        nxt        = cur;
        event_code = EV_NONE;
        rc_mid     = cur.repeat_count;
        if (req_type == REQ_TICK)
        begin
            if (cur.tick_phase == 16'd0)
            begin
                nxt.second = sec_adv;
                nxt.minute = min_adv;
                nxt.hour   = hour_adv;
            end
            nxt.tick_phase = (cur.tick_phase >= tps_eff - 16'd1) ? 16'd0
                                                                 : cur.tick_phase + 16'd1;
        end
        else
        begin
            nxt.last_key_ms = now_ms;
            if (key_code == KEY_SELECT)
            begin
                case (cur.mode)
                    MODE_NORMAL:
                    begin
                        if (lp_hit)
                            rc_mid = rc_inc;
                        else if (slow)
                        begin
                            nxt.mode   = MODE_TIME_SET;
                            rc_mid     = 8'd0;
                            event_code = EV_TIME_SET;
                        end
                        nxt.repeat_count = rc_mid;
                        if (rc_mid >= cfg.lp_repeats)
                        begin
                            nxt.mode         = MODE_ALARM_SET;
                            nxt.repeat_count = 8'd0;
                            event_code       = EV_ALARM_SET;
                        end
                    end
                    MODE_TIME_SET:
                    begin
                        if (slow)
                        begin
                            nxt.field = FIELD_AMPM;
                            nxt.mode  = MODE_NORMAL;
                        end
                        else if (dc_hit)
                        begin
                            nxt.mode         = MODE_MUSIC;
                            nxt.repeat_count = 8'd0;
                            event_code       = EV_MUSIC;
                        end
                    end
                    MODE_ALARM_SET:
                    begin
                        if (slow)
                        begin
                            nxt.field = FIELD_AMPM;
                            nxt.mode  = MODE_NORMAL;
                        end
                    end
                    default:
                    begin
                        if (slow)
                            nxt.mode = MODE_NORMAL;
                    end
                endcase
            end
            else if (key_code == KEY_UP || key_code == KEY_DOWN)
            begin
                if (cur.mode == MODE_TIME_SET)
                begin
                    case (cur.field)
                        FIELD_AMPM, FIELD_HOUR: nxt.hour   = sat8(hour_sum);
                        FIELD_MIN:              nxt.minute = sat8(min_sum);
                        FIELD_SEC:              nxt.second = sat8(sec_sum);
                        default:                ;
                    endcase
                end
                else if (cur.mode == MODE_ALARM_SET)
                begin
                    case (cur.field)
                        FIELD_AMPM, FIELD_HOUR:
                            nxt.al_hour = 4'(alarm_clamp(al_hour_sum, 10'sd12));
                        FIELD_MIN: nxt.al_min = alarm_clamp(al_min_sum, 10'sd60);
                        FIELD_SEC: nxt.al_sec = alarm_clamp(al_sec_sum, 10'sd60);
                        default:   ;
                    endcase
                end
                else if (cur.mode == MODE_MUSIC)
                    event_code = is_up ? EV_SONG_ONE : EV_SONG_TWO;
            end
            else if (key_code == KEY_RIGHT || key_code == KEY_LEFT)
            begin
                if (cur.mode == MODE_TIME_SET || cur.mode == MODE_ALARM_SET)
                    nxt.field = (key_code == KEY_RIGHT) ? field_right : field_left;
            end
        end
    end

endmodule

// ----- test/cmts_checker.sv -----
// ----------------------------------------------------------------------------
// cmts_checker
// Watches the request, result and configuration ports of the clock mode and
// time setter, predicts each result from its own copy of the clock state and
// timing registers, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module cmts_checker
    import cmts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  req_type,
    input  logic [7:0]            key_code,
    input  logic [31:0]           now_ms,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            op_mode,
    input  logic [2:0]            field_select,
    input  logic signed [7:0]     hours,
    input  logic signed [7:0]     minutes,
    input  logic signed [7:0]     seconds,
    input  logic [3:0]            alarm_hours,
    input  logic [5:0]            alarm_minutes,
    input  logic [5:0]            alarm_seconds,
    input  logic [2:0]            event_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output mode_t                 mode_now
);

    // One predicted result: the visible state plus the event
    typedef struct packed {
        mode_t             mode;
        logic [2:0]        field;
        logic signed [7:0] hour;
        logic signed [7:0] minute;
        logic signed [7:0] second;
        logic [3:0]        al_hour;
        logic [5:0]        al_min;
        logic [5:0]        al_sec;
        logic [2:0]        ev;
    } clock_view_t;

    cfg_t         timing;
    clock_state_t clk_state;
    clock_view_t  due_q[$];
    int           fails = 0;

    // Clip a time count to the signed byte range
    function automatic logic [7:0] sat_time(input int v);
        if (v > 127)
            return 8'h7F;
        if (v < -128)
            return 8'h80;
        return v[7:0];
    endfunction

    // Alarm values outside 1..hi fall back to zero
    function automatic int alarm_limit(input int v, input int hi);
        return (v > hi || v <= 0) ? 0 : v;
    endfunction

    task automatic reset_model();
        timing.lp_min     = 16'd20;
        timing.lp_max     = 16'd50;
        timing.lp_repeats = 8'd30;
        timing.dc_min     = 16'd100;
        timing.dc_max     = 16'd200;
        timing.sc_min     = 16'd500;
        timing.tps        = 16'd100;
        clk_state         = '0;
        clk_state.mode    = MODE_NORMAL;
        clk_state.field   = FIELD_AMPM;
        due_q.delete();
    endtask

    task automatic write_timing();
        case (cfg_index)
            CFG_LP_MIN:     timing.lp_min = cfg_data;
            CFG_LP_MAX:     timing.lp_max = cfg_data;
            CFG_LP_REPEATS: timing.lp_repeats = cfg_data[7:0];
            CFG_DC_MIN:     timing.dc_min = cfg_data;
            CFG_DC_MAX:     timing.dc_max = cfg_data;
            CFG_SC_MIN:     timing.sc_min = cfg_data;
            CFG_TPS:        timing.tps = cfg_data;
            default:        ;
        endcase
    endtask

    // Advance the seconds and normalise the whole time of day
    task automatic advance_second();
        int s, m, h;
        s = $signed(clk_state.second) + 1;
        m = $signed(clk_state.minute);
        h = $signed(clk_state.hour);
        if (s >= 60)
        begin
            m = m + 1;
            s = 0;
        end
        else if (s < 0)
            s = 0;
        if (m >= 60)
        begin
            h = h + 1;
            m = 0;
        end
        else if (m < 0)
            m = 0;
        if (h >= 24 || h < 0)
            h = 0;
        clk_state.second = s[7:0];
        clk_state.minute = m[7:0];
        clk_state.hour   = h[7:0];
    endtask

    // Up and down on the selected field of the time or the alarm
    task automatic adjust_value(input int d);
        int a;
        if (clk_state.mode == MODE_TIME_SET)
        begin
            case (clk_state.field)
                FIELD_AMPM: clk_state.hour   = sat_time($signed(clk_state.hour) + 12 * d);
                FIELD_HOUR: clk_state.hour   = sat_time($signed(clk_state.hour) + d);
                FIELD_MIN:  clk_state.minute = sat_time($signed(clk_state.minute) + d);
                FIELD_SEC:  clk_state.second = sat_time($signed(clk_state.second) + d);
                default:    ;
            endcase
        end
        else
        begin
            case (clk_state.field)
                FIELD_AMPM:
                begin
                    a = alarm_limit(int'(clk_state.al_hour) + 12 * d, 12);
                    clk_state.al_hour = a[3:0];
                end
                FIELD_HOUR:
                begin
                    a = alarm_limit(int'(clk_state.al_hour) + d, 12);
                    clk_state.al_hour = a[3:0];
                end
                FIELD_MIN:
                begin
                    a = alarm_limit(int'(clk_state.al_min) + d, 60);
                    clk_state.al_min = a[5:0];
                end
                FIELD_SEC:
                begin
                    a = alarm_limit(int'(clk_state.al_sec) + d, 60);
                    clk_state.al_sec = a[5:0];
                end
                default: ;
            endcase
        end
    endtask

    // Select key: mode changes by the interval since the previous key
    task automatic handle_select(input logic [31:0] gap, inout logic [2:0] ev);
        case (clk_state.mode)
            MODE_NORMAL:
            begin
                if (gap >= timing.lp_min && gap <= timing.lp_max)
                begin
                    if (clk_state.repeat_count != 8'hFF)
                        clk_state.repeat_count = clk_state.repeat_count + 8'd1;
                end
                else if (gap >= timing.sc_min)
                begin
                    clk_state.mode         = MODE_TIME_SET;
                    clk_state.repeat_count = '0;
                    ev                     = EV_TIME_SET;
                end
                // long press wins over a plain select
                if (clk_state.repeat_count >= timing.lp_repeats)
                begin
                    clk_state.mode         = MODE_ALARM_SET;
                    clk_state.repeat_count = '0;
                    ev                     = EV_ALARM_SET;
                end
            end
            MODE_TIME_SET:
            begin
                if (gap >= timing.sc_min)
                begin
                    clk_state.field = FIELD_AMPM;
                    clk_state.mode  = MODE_NORMAL;
                end
                else if (gap >= timing.dc_min && gap <= timing.dc_max)
                begin
                    clk_state.mode         = MODE_MUSIC;
                    clk_state.repeat_count = '0;
                    ev                     = EV_MUSIC;
                end
            end
            MODE_ALARM_SET:
            begin
                if (gap >= timing.sc_min)
                begin
                    clk_state.field = FIELD_AMPM;
                    clk_state.mode  = MODE_NORMAL;
                end
            end
            default:
            begin
                if (gap >= timing.sc_min)
                    clk_state.mode = MODE_NORMAL;
            end
        endcase
    endtask

    // Apply one accepted request and queue the result it must produce
    task automatic predict_result();
        clock_view_t due;
        logic [2:0]  ev;
        logic [31:0] gap;
        logic [15:0] rate;
        ev = EV_NONE;
        if (req_type == REQ_TICK)
        begin
            rate = (timing.tps == 16'd0) ? 16'd1 : timing.tps;
            if (clk_state.tick_phase == 16'd0)
                advance_second();
            clk_state.tick_phase = (clk_state.tick_phase >= rate - 16'd1) ?
                                   16'd0 : clk_state.tick_phase + 16'd1;
        end
        else
        begin
            gap = now_ms - clk_state.last_key_ms;
            clk_state.last_key_ms = now_ms;
            if (key_code == KEY_SELECT)
                handle_select(gap, ev);
            else if (key_code == KEY_UP || key_code == KEY_DOWN)
            begin
                if (clk_state.mode == MODE_MUSIC)
                    ev = (key_code == KEY_UP) ? EV_SONG_ONE : EV_SONG_TWO;
                else if (clk_state.mode != MODE_NORMAL)
                    adjust_value((key_code == KEY_UP) ? 1 : -1);
            end
            else if ((key_code == KEY_RIGHT || key_code == KEY_LEFT) &&
                     (clk_state.mode == MODE_TIME_SET || clk_state.mode == MODE_ALARM_SET))
            begin
                if (key_code == KEY_RIGHT)
                    clk_state.field = (clk_state.field >= FIELD_SEC || clk_state.field == '0) ?
                                      FIELD_AMPM : clk_state.field + 3'd1;
                else
                    clk_state.field = (clk_state.field <= FIELD_AMPM ||
                                       clk_state.field > FIELD_SEC) ?
                                      FIELD_SEC : clk_state.field - 3'd1;
            end
        end
        due.mode    = clk_state.mode;
        due.field   = clk_state.field;
        due.hour    = clk_state.hour;
        due.minute  = clk_state.minute;
        due.second  = clk_state.second;
        due.al_hour = clk_state.al_hour;
        due.al_min  = clk_state.al_min;
        due.al_sec  = clk_state.al_sec;
        due.ev      = ev;
        due_q.push_back(due);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Compare a delivered result with the oldest prediction
    task automatic check_result();
        clock_view_t due;
        if (due_q.size() == 0)
        begin
            $error("result with no request outstanding: mode %0d, event %0d",
                   op_mode, event_code);
            fails++;
        end
        else
        begin
            due = due_q.pop_front();
            check_field("op_mode", due.mode, op_mode);
            check_field("field_select", due.field, field_select);
            check_field("hours", due.hour, hours);
            check_field("minutes", due.minute, minutes);
            check_field("seconds", due.second, seconds);
            check_field("alarm_hours", due.al_hour, alarm_hours);
            check_field("alarm_minutes", due.al_min, alarm_minutes);
            check_field("alarm_seconds", due.al_sec, alarm_seconds);
            check_field("event_code", due.ev, event_code);
        end
    endtask

    // Sample all three ports at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_model();
        else
        begin
            if (cfg_we)
                write_timing();
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_result();
        end
        pending    <= due_q.size();
        fail_count <= fails;
        mode_now   <= clk_state.mode;
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives tick and key requests into the clock mode and time setter under
// several timing settings, with random idling on both channels, and reports
// the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
    import cmts_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef enum {GAP_LONG, GAP_DOUBLE, GAP_SLOW, GAP_ANY} gap_kind_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  req_type = REQ_TICK;
    logic [7:0]            key_code = '0;
    logic [31:0]           now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            op_mode;
    logic [2:0]            field_select;
    logic signed [7:0]     hours;
    logic signed [7:0]     minutes;
    logic signed [7:0]     seconds;
    logic [3:0]            alarm_hours;
    logic [5:0]            alarm_minutes;
    logic [5:0]            alarm_seconds;
    logic [2:0]            event_code;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    mode_t       mode_now;
    int          idle_pct = 25;
    int          stall_pct = 25;
    int          cycle_count = 0;
    logic [31:0] key_ms = '0;
    cfg_t        timing;

    clock_mode_and_time_setter u_top (.*);
    cmts_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Stop a hung run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Interval to the next key, shaped by the current timing windows
    function automatic logic [31:0] pick_gap(input gap_kind_t kind);
        int r;
        r = $urandom_range(0, 3);
        case (kind)
            GAP_LONG:   return $urandom_range(timing.lp_max, timing.lp_min);
            GAP_DOUBLE: return $urandom_range(timing.dc_max, timing.dc_min);
            GAP_SLOW:   return $urandom_range(timing.sc_min + 32'd3000, timing.sc_min);
            default:
            begin
                if (r == 0)
                    return $urandom;
                if (r == 1)
                    return $urandom_range(0, 70000);
                return $urandom_range(0, 1000);
            end
        endcase
    endfunction

    // Offer one request and hold it until it is taken
    task automatic send_request(input logic rt, input logic [7:0] key,
                                input logic [31:0] ms);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        key_code <= key;
        now_ms   <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic press(input logic [7:0] key, input logic [31:0] gap);
        key_ms = key_ms + gap;
        send_request(REQ_KEY, key, key_ms);
    endtask

    // Tick payload is ignored by the block, so fill it with noise
    task automatic tick_once();
        send_request(REQ_TICK, 8'($urandom_range(0, 255)), $urandom);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] lp_lo, input logic [15:0] lp_hi,
                              input logic [7:0] reps, input logic [15:0] dc_lo,
                              input logic [15:0] dc_hi, input logic [15:0] sc,
                              input logic [15:0] rate);
        timing.lp_min     = lp_lo;
        timing.lp_max     = lp_hi;
        timing.lp_repeats = reps;
        timing.dc_min     = dc_lo;
        timing.dc_max     = dc_hi;
        timing.sc_min     = sc;
        timing.tps        = rate;
        set_register(CFG_LP_MIN, lp_lo);
        set_register(CFG_LP_MAX, lp_hi);
        // upper byte of the repeat count is dropped by the block
        set_register(CFG_LP_REPEATS, {8'($urandom_range(0, 255)), reps});
        set_register(CFG_DC_MIN, dc_lo);
        set_register(CFG_DC_MAX, dc_hi);
        set_register(CFG_SC_MIN, sc);
        set_register(CFG_TPS, rate);
    endtask

    // Leave a setting mode with a slow select; call only when drained
    task automatic to_normal();
        if (mode_now != MODE_NORMAL)
        begin
            press(KEY_SELECT, pick_gap(GAP_SLOW));
            drain_results();
        end
    endtask

    // Mostly well-timed key runs and tick bursts, some noise
    task automatic random_traffic(input int n);
        int         done_items;
        int         r;
        int         len;
        logic [7:0] key;
        done_items = 0;
        while (done_items < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                len = $urandom_range(1, 8);
                repeat (len) tick_once();
            end
            else if (r < 50)
            begin
                len = 1;
                press(KEY_SELECT, pick_gap(gap_kind_t'($urandom_range(0, 3))));
            end
            else if (r < 72)
            begin
                key = $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 26)
                                                  : $urandom_range(1, 3);
                repeat (len) press(key, pick_gap(GAP_ANY));
            end
            else if (r < 85)
            begin
                key = $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT;
                len = $urandom_range(1, 3);
                repeat (len) press(key, pick_gap(GAP_ANY));
            end
            else if (r < 92)
            begin
                len = 1;
                press(8'($urandom_range(0, 255)), pick_gap(GAP_ANY));
            end
            else
            begin
                // held select: enough repeats to reach alarm setting while lp_repeats is below 40, else 40
                len = (timing.lp_repeats < 40) ? timing.lp_repeats + 2 : 40;
                repeat (len) press(KEY_SELECT, pick_gap(GAP_LONG));
            end
            done_items += len;
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        timing.lp_min     = 16'd20;
        timing.lp_max     = 16'd50;
        timing.lp_repeats = 8'd30;
        timing.dc_min     = 16'd100;
        timing.dc_max     = 16'd200;
        timing.sc_min     = 16'd500;
        timing.tps        = 16'd100;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timings: first tick advances, wrap of the key interval,
        // time setting, field wrap, adjust, music select and songs
        tick_once();
        tick_once();
        press(8'h00, 32'd0);
        key_ms = 32'hFFFF_FFFF;
        send_request(REQ_KEY, 8'hFF, key_ms);
        press(KEY_SELECT, 32'd600);
        press(KEY_RIGHT, 32'd5);
        press(KEY_UP, 32'd5);
        press(KEY_LEFT, 32'd5);
        press(KEY_LEFT, 32'd5);
        press(KEY_DOWN, 32'd5);
        press(KEY_DOWN, 32'd5);
        press(KEY_RIGHT, 32'd5);
        press(KEY_UP, 32'd5);
        press(KEY_SELECT, 32'd150);
        press(KEY_UP, 32'd5);
        press(KEY_DOWN, 32'd5);
        press(KEY_SELECT, 32'd10);
        press(KEY_SELECT, 32'd500);
        press(KEY_SELECT, 32'd30);
        press(KEY_SELECT, 32'd100);
        send_request(REQ_TICK, KEY_SELECT, $urandom);
        random_traffic(200);

        // Short long press: alarm setting, alarm wrap and clamp
        drain_results();
        set_timing(16'd20, 16'd50, 8'd3, 16'd100, 16'd200, 16'd500, 16'd2);
        to_normal();
        repeat (3) press(KEY_SELECT, 32'd30);
        press(KEY_UP, 32'd5);
        press(KEY_UP, 32'd5);
        press(KEY_RIGHT, 32'd5);
        press(KEY_DOWN, 32'd5);
        press(KEY_UP, 32'd5);
        press(KEY_SELECT, 32'd900);
        random_traffic(200);

        // Widest windows: every select is a repeat, count runs to the top
        drain_results();
        set_timing(16'd0, 16'hFFFF, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        to_normal();
        repeat (257) press(KEY_SELECT, $urandom_range(0, 1000));
        random_traffic(150);

        // All zero: zero repeats and zero tick rate
        drain_results();
        set_timing(16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_traffic(180);

        // Fastest rate with no idling on either side
        drain_results();
        set_timing(16'd10, 16'd30, 8'd1, 16'd40, 16'd80, 16'd100, 16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(280);
        idle_pct  = 25;
        stall_pct = 25;

        // Random windows, and a write to the unused index
        drain_results();
        set_register(CFG_SPARE, 16'($urandom_range(0, 65535)));
        timing.lp_min = 16'($urandom_range(0, 60));
        timing.dc_min = 16'($urandom_range(0, 300));
        set_timing(timing.lp_min,
                   16'($urandom_range(timing.lp_min, timing.lp_min + 100)),
                   8'($urandom_range(1, 8)), timing.dc_min,
                   16'($urandom_range(timing.dc_min, 600)),
                   16'($urandom_range(200, 2000)),
                   16'($urandom_range(1, 20)));
        random_traffic(230);

        // Repeat window overlapping the slow select threshold
        drain_results();
        set_timing(16'd400, 16'd700, 8'd4, 16'd100, 16'd200, 16'd500, 16'd5);
        random_traffic(200);

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
